>>> rtl/core/assert_macros.svh
// assertion macros for the rtl files, included by date_add_days_top
// no dependencies; include by bare file name inside a module body
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) else $error(msg);

// same-cycle implication checked outside reset
`define ASSERT_IMPLIES(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) else $error(msg);

// next-cycle implication checked outside reset
`define ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/dad_pkg.sv
// types, constants and the month length function for the date adder
// no dependencies; used by dad_ctrl, dad_datapath and date_add_days_top
`timescale 1ns / 1ps

package dad_pkg;

  localparam logic [3:0]  MONTH_JAN = 4'd1;
  localparam logic [3:0]  MONTH_FEB = 4'd2;
  localparam logic [3:0]  MONTH_APR = 4'd4;
  localparam logic [3:0]  MONTH_JUN = 4'd6;
  localparam logic [3:0]  MONTH_SEP = 4'd9;
  localparam logic [3:0]  MONTH_NOV = 4'd11;
  localparam logic [3:0]  MONTH_DEC = 4'd12;

  localparam logic [4:0]  DAYS_31 = 5'd31;
  localparam logic [4:0]  DAYS_30 = 5'd30;
  localparam logic [4:0]  DAYS_29 = 5'd29;
  localparam logic [4:0]  DAYS_28 = 5'd28;
  localparam logic [4:0]  DAY_FIRST = 5'd1;

  localparam logic [13:0] YEAR_MAX = 14'd9999;

  localparam logic [1:0]  ST_OK       = 2'd0;
  localparam logic [1:0]  ST_BAD_DATE = 2'd1;
  localparam logic [1:0]  ST_YEAR_OVF = 2'd2;

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [15:0] days_to_add;
  } dad_req_t;

  typedef struct packed {
    logic [4:0]  new_day;
    logic [3:0]  new_month;
    logic [13:0] new_year;
    logic [1:0]  status;
  } dad_rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic capture;
  } dad_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic finish;
  } dad_sts_t;

  // leap is every fourth year, centuries included
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    begin
      len = DAYS_31;
      if (m == MONTH_FEB) begin
        len = leap ? DAYS_29 : DAYS_28;
      end else if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV) begin
        len = DAYS_30;
      end
      return len;
    end
  endfunction

endpackage

>>> rtl/core/dad_datapath.sv
// datapath of the date adder: date and day count registers, month step, result register
// depends on dad_pkg
`timescale 1ns / 1ps

module dad_datapath #(
  parameter int DAY_COUNT_BITS = 16
) (
  input  logic              clk,
  input  dad_pkg::dad_cmd_t cmd,
  output dad_pkg::dad_sts_t sts,
  input  dad_pkg::dad_req_t req_data,
  output dad_pkg::dad_rsp_t rsp_data
);
  import dad_pkg::*;

  logic [4:0]                d;
  logic [3:0]                m;
  logic [13:0]               y;
  logic [DAY_COUNT_BITS-1:0] n;
  logic                      bad;

  logic [4:0]                mlen;
  logic [4:0]                left;
  logic                      ovf;
  logic                      fits;
  logic [DAY_COUNT_BITS-1:0] n_next;
  logic [4:0]                in_mlen;
  logic                      in_bad;
  dad_rsp_t                  result;

  assign mlen   = month_len(m, y[1:0] == 2'b00);
  assign left   = mlen - d;
  assign ovf    = (y > YEAR_MAX);
  assign fits   = (n <= DAY_COUNT_BITS'(left));
  // consume the rest of this month and move to the first of the next
  assign n_next = n - DAY_COUNT_BITS'({1'b0, left} + 6'd1);

  assign sts.finish = bad | ovf | fits;

  assign in_mlen = month_len(req_data.month, req_data.year[1:0] == 2'b00);
  assign in_bad  = (req_data.month == 4'd0) || (req_data.month > MONTH_DEC) ||
                   (req_data.day == 5'd0) || (req_data.day > in_mlen);

  always_comb begin
    result.new_day   = d;
    result.new_month = m;
    result.new_year  = y;
    result.status    = ST_BAD_DATE;
    if (!bad) begin
      if (ovf) begin
        result.new_day   = DAYS_31;
        result.new_month = MONTH_DEC;
        result.new_year  = YEAR_MAX;
        result.status    = ST_YEAR_OVF;
      end else begin
        // n is at most left here, so it fits in five bits
        result.new_day = d + n[4:0];
        result.status  = ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      d   <= req_data.day;
      m   <= req_data.month;
      y   <= req_data.year;
      n   <= DAY_COUNT_BITS'(req_data.days_to_add);
      bad <= in_bad;
    end else if (cmd.step) begin
      d <= DAY_FIRST;
      n <= n_next;
      if (m == MONTH_DEC) begin
        m <= MONTH_JAN;
        y <= y + 14'd1;
      end else begin
        m <= m + 4'd1;
      end
    end
    if (cmd.capture) begin
      rsp_data <= result;
    end
  end

endmodule

>>> rtl/core/dad_ctrl.sv
// controller of the date adder: request/response handshakes and step sequencing
// depends on dad_pkg
`timescale 1ns / 1ps

module dad_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output dad_pkg::dad_cmd_t cmd,
  input  dad_pkg::dad_sts_t sts
);
  import dad_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  state_t state;
  logic   slot_free;

  assign req_stall = (state != S_IDLE);
  // result register can take a new value when empty or drained this cycle
  assign slot_free = !rsp_valid || !rsp_stall;

  always_comb begin
    cmd.load    = (state == S_IDLE) && req_valid;
    cmd.step    = (state == S_RUN) && !sts.finish;
    cmd.capture = (state == S_RUN) && sts.finish && slot_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.capture) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (cmd.capture) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/core/date_add_days_top.sv
// Date adder: adds a day count to a calendar date (leap year every fourth year, centuries
// included) and returns the new date with a status of ok, bad input date or year overflow
// saturated at 31 December 9999. One transaction is worked at a time: it is loaded, then
// the month step loop retires one month per cycle until the count fits in the month, the
// date is bad or the year overflows, and the result is captured once the output register
// is free. A new request is taken while a finished response still waits in the output
// register.
// depends on dad_pkg, dad_ctrl, dad_datapath and assert_macros.svh
`timescale 1ns / 1ps

module date_add_days_top #(
  parameter int DAY_COUNT_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  dad_pkg::dad_req_t req_data,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output dad_pkg::dad_rsp_t rsp_data
);
  import dad_pkg::*;
  `include "assert_macros.svh"

  dad_cmd_t cmd;
  dad_sts_t sts;

  dad_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  dad_datapath #(
    .DAY_COUNT_BITS (DAY_COUNT_BITS)
  ) u_datapath (
    .clk      (clk),
    .cmd      (cmd),
    .sts      (sts),
    .req_data (req_data),
    .rsp_data (rsp_data)
  );

  // an accepted request keeps the input closed until its result is captured
  `ASSERT_NEXT(a_busy_after_req, clk, rst, req_valid && !req_stall, req_stall, "request taken while busy")

  // a response appears only from a capture
  `ASSERT_IMPLIES(a_rsp_from_capture, clk, rst, $rose(rsp_valid), $past(cmd.capture), "response without capture")

  // stepping and capturing are exclusive
  `ASSERT_ALWAYS(a_step_xor_capture, clk, rst, !(cmd.step && cmd.capture), "step and capture together")

  // response status is one of the defined codes
  `ASSERT_IMPLIES(a_status_code, clk, rst, rsp_valid, rsp_data.status == ST_OK || rsp_data.status == ST_BAD_DATE || rsp_data.status == ST_YEAR_OVF, "bad status code")

endmodule

>>> dv/tb_date_add_days_top.sv
// testbench for date_add_days_top: random and directed dates with a day count to add
// depends on dad_pkg and the date adder rtl; checks every response against its own predictor
`timescale 1ns / 1ps

module tb_date_add_days_top;
  import dad_pkg::*;

  localparam int IDLE_PCT = 27;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_stall;
  dad_req_t req_data = '0;
  logic     rsp_valid;
  logic     rsp_stall = 1'b0;
  dad_rsp_t rsp_data;

  dad_req_t pending_reqs[$];
  dad_rsp_t due_dates[$];
  logic     req_taken = 1'b0;
  int       reqs_taken_count = 0;
  int       dates_seen = 0;
  int       mismatch_count = 0;

  date_add_days_top dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // every fourth year is leap, centuries too
  function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
    int unsigned len;
    len = DAYS_31;
    if (m == MONTH_FEB) begin
      len = (y % 4 == 0) ? DAYS_29 : DAYS_28;
    end else if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV) begin
      len = DAYS_30;
    end
    return len;
  endfunction

  function automatic dad_rsp_t later_date(dad_req_t r);
    int unsigned d;
    int unsigned m;
    int unsigned y;
    int unsigned n;
    int unsigned left;
    dad_rsp_t res;
    d = r.day;
    m = r.month;
    y = r.year;
    n = r.days_to_add;
    res.status = ST_OK;
    if (m < MONTH_JAN || m > MONTH_DEC || d < DAY_FIRST || d > days_in_month(m, y)) begin
      res.status = ST_BAD_DATE;
    end else begin
      // walk month by month until the remaining count fits
      while (y <= YEAR_MAX) begin
        left = days_in_month(m, y) - d;
        if (n <= left) begin
          d = d + n;
          break;
        end
        n = n - (left + 1);
        d = DAY_FIRST;
        m = m + 1;
        if (m > MONTH_DEC) begin
          m = MONTH_JAN;
          y = y + 1;
        end
      end
      if (y > YEAR_MAX) begin
        res.status = ST_YEAR_OVF;
        d = DAYS_31;
        m = MONTH_DEC;
        y = YEAR_MAX;
      end
    end
    res.new_day   = 5'(d);
    res.new_month = 4'(m);
    res.new_year  = 14'(y);
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("ERROR at %0t: %s got %0d want %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic add_date(int d, int m, int y, int n);
    dad_req_t r;
    r.day         = 5'(d);
    r.month       = 4'(m);
    r.year        = 14'(y);
    r.days_to_add = 16'(n);
    pending_reqs.push_back(r);
  endtask

  // driver: a new transaction is presented only once the previous one was taken
  always @(negedge clk) begin
    if (!rst && (!req_valid || req_taken)) begin
      if (pending_reqs.size() != 0 &&
          ((reqs_taken_count inside {[120:180]}) || $urandom_range(99) >= IDLE_PCT)) begin
        req_valid <= 1'b1;
        req_data  <= pending_reqs.pop_front();
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // receiver stalls, with a quiet stretch in the middle of the run
  always @(negedge clk) begin
    rsp_stall <= !rst && !(dates_seen inside {[110:170]}) && ($urandom_range(99) < IDLE_PCT);
  end

  // monitor
  always @(posedge clk) begin
    dad_rsp_t want;
    req_taken <= !rst && req_valid && !req_stall;
    if (!rst) begin
      if (req_valid && !req_stall) begin
        due_dates.push_back(later_date(req_data));
        reqs_taken_count++;
      end
      if (rsp_valid && !rsp_stall) begin
        dates_seen++;
        if (due_dates.size() == 0) begin
          report_mismatch("unexpected response, new_day", rsp_data.new_day, 0);
        end else begin
          want = due_dates.pop_front();
          if (rsp_data.new_day !== want.new_day)
            report_mismatch("new_day", rsp_data.new_day, want.new_day);
          if (rsp_data.new_month !== want.new_month)
            report_mismatch("new_month", rsp_data.new_month, want.new_month);
          if (rsp_data.new_year !== want.new_year)
            report_mismatch("new_year", rsp_data.new_year, want.new_year);
          if (rsp_data.status !== want.status)
            report_mismatch("status", rsp_data.status, want.status);
        end
      end
    end
  end

  initial begin
    int m;
    int y;
    int d;
    int n;
    int pick;

    // directed corners
    add_date(31, MONTH_DEC, 9999, 0);
    add_date(31, MONTH_DEC, 9999, 1);
    add_date(28, MONTH_FEB, 2023, 1);
    add_date(28, MONTH_FEB, 2024, 1);
    add_date(29, MONTH_FEB, 2023, 0);
    add_date(29, MONTH_FEB, 1900, 0);
    add_date(29, MONTH_FEB, 2100, 365);
    add_date(0, MONTH_JAN, 2000, 5);
    add_date(15, 0, 2000, 5);
    add_date(1, 13, 2000, 5);
    add_date(31, 15, 16383, 65535);
    add_date(31, MONTH_APR, 2010, 0);
    add_date(31, MONTH_JUN, 2010, 3);
    add_date(0, 0, 0, 0);
    add_date(1, MONTH_JAN, 0, 65535);
    add_date(1, MONTH_JAN, 10000, 0);
    add_date(31, MONTH_DEC, 16383, 0);
    add_date(31, MONTH_JAN, 2000, 65535);
    add_date(1, MONTH_JAN, 9990, 65535);
    add_date(30, MONTH_DEC, 1999, 2);
    add_date(15, MONTH_JUN, 2020, 0);
    add_date(30, MONTH_SEP, 9999, 92);
    add_date(31, MONTH_DEC, 9998, 366);

    repeat (250) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        // anything the fields allow, bad dates included
        d = $urandom_range(31);
        m = $urandom_range(15);
        y = $urandom_range(16383);
        n = $urandom_range(65535);
      end else begin
        m = $urandom_range(MONTH_DEC, MONTH_JAN);
        pick = $urandom_range(99);
        if (pick < 70)      y = $urandom_range(2100, 1900);
        else if (pick < 85) y = $urandom_range(9999);
        else if (pick < 93) y = $urandom_range(9999, 9900);
        else                y = $urandom_range(16383, 10000);
        d = ($urandom_range(3) == 0) ? days_in_month(m, y) : $urandom_range(days_in_month(m, y), 1);
        pick = $urandom_range(99);
        if (pick < 55)      n = $urandom_range(60);
        else if (pick < 85) n = $urandom_range(1500);
        else if (pick < 95) n = $urandom_range(65535);
        else                n = 65535 - $urandom_range(100);
      end
      add_date(d, m, y, n);
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || req_valid) @(posedge clk);
    while (due_dates.size() != 0) @(posedge clk);
    repeat (2300) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // hang guard, far above the slowest legal run
  initial begin
    #20000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
